@@ hw/rtl/pmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pmt_pkg;

    localparam int MAX_SOURCES     = 4;
    localparam int DEF_NUM_SOURCES = 4;

    localparam int SRC_W      = 2;
    localparam int OWNER_W    = 3;
    localparam int PRIO_W     = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int PAYLOAD_W  = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // slave tdata: source, payload; master tdata: payload_out, owner_changed, owner
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [OWNER_W-1:0]   VACANT_CODE   = 3'd4;

    localparam logic CMD_COMMAND = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PRIORITY0 = 3'd0,
        REG_PRIORITY1 = 3'd1,
        REG_PRIORITY2 = 3'd2,
        REG_PRIORITY3 = 3'd3,
        REG_TIMEOUT0  = 3'd4,
        REG_TIMEOUT1  = 3'd5,
        REG_TIMEOUT2  = 3'd6,
        REG_TIMEOUT3  = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic                 forward;
        logic [PAYLOAD_W-1:0] payload_out;
        logic                 owner_changed;
        logic [OWNER_W-1:0]   owner;
    } pmt_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/priority_mux_with_timeouts_top.sv @@
// channel   direction  tdata (low bit up)                             tuser
// s_axis    in         source[1:0], payload[65:2], zero pad to 72     cmd (0 command, 1 tick)
// m_axis    out        payload_out[63:0], owner_changed[64],          forward
//                      owner[67:65], zero pad to 72
// cfg       in         cfg_we, cfg_addr (register index), cfg_wdata   -
//
// one transfer per cycle each way unless stalled; results show the cycle after their input
// owner and timer state update at the input transfer, a single output register holds results
// s_axis_tready stays high while the output register is empty or being drained
// reset: owner vacant, all timers stopped, priorities 0, timeouts 1000
`timescale 1ns / 1ps
`default_nettype none

module priority_mux_with_timeouts_top
    import pmt_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // source, payload
    input  wire logic                  s_axis_tuser,  // cmd

    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [M_TDATA_W-1:0]  m_axis_tdata,  // payload_out, owner_changed, owner
    output      logic                  m_axis_tuser   // forward
);

    logic        accept;
    pmt_result_t result;
    logic        out_valid_reg;
    pmt_result_t out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    pmt_core #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .cmd       (s_axis_tuser),
        .source    (s_axis_tdata[SRC_W-1:0]),
        .payload   (s_axis_tdata[SRC_W +: PAYLOAD_W]),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.forward;
    assign m_axis_tdata  = {(M_TDATA_W - PAYLOAD_W - 1 - OWNER_W)'(0),
                            out_data_reg.owner,
                            out_data_reg.owner_changed,
                            out_data_reg.payload_out};

endmodule

`default_nettype wire

@@ hw/rtl/pmt_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pmt_core
    import pmt_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  accept,
    input  wire logic                  cmd,
    input  wire logic [SRC_W-1:0]      source,
    input  wire logic [PAYLOAD_W-1:0]  payload,
    output pmt_result_t                result
);

    logic [PRIO_W-1:0]    prio_reg    [NUM_SOURCES];
    logic [TIMEOUT_W-1:0] timeout_reg [NUM_SOURCES];
    logic [TIMEOUT_W-1:0] cnt_reg     [NUM_SOURCES];
    logic [TIMEOUT_W-1:0] cnt_next    [NUM_SOURCES];
    logic [OWNER_W-1:0]   owner_reg;
    logic [OWNER_W-1:0]   owner_next;

    logic [OWNER_W-1:0]   src_code;
    logic                 src_ok;
    logic [PRIO_W-1:0]    owner_prio;
    logic [PRIO_W-1:0]    src_prio;
    logic                 take;

    assign src_code = {1'b0, source};
    assign src_ok   = src_code < OWNER_W'(NUM_SOURCES);

    always_comb
    begin
        owner_prio = '0;
        src_prio   = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (owner_reg == OWNER_W'(i))
            begin
                owner_prio = prio_reg[i];
            end
            if (src_code == OWNER_W'(i))
            begin
                src_prio = prio_reg[i];
            end
        end
        take = (owner_reg >= VACANT_CODE) || (owner_reg == src_code) ||
               (src_prio > owner_prio);
    end

    always_comb
    begin
        owner_next = owner_reg;
        result     = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end

        if (cmd == CMD_COMMAND)
        begin
            if (src_ok)
            begin
                for (int i = 0; i < NUM_SOURCES; i++)
                begin
                    if (src_code == OWNER_W'(i))
                    begin
                        // a zero timeout still runs for one tick
                        cnt_next[i] = (timeout_reg[i] == '0) ? TIMEOUT_W'(1) : timeout_reg[i];
                    end
                end
                if (take)
                begin
                    result.forward     = 1'b1;
                    result.payload_out = payload;
                    if (owner_reg != src_code)
                    begin
                        owner_next           = src_code;
                        result.owner_changed = 1'b1;
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                if (cnt_reg[i] != '0)
                begin
                    cnt_next[i] = cnt_reg[i] - TIMEOUT_W'(1);
                    if ((cnt_reg[i] == TIMEOUT_W'(1)) && (owner_reg == OWNER_W'(i)))
                    begin
                        owner_next           = VACANT_CODE;
                        result.owner_changed = 1'b1;
                    end
                end
            end
        end
        result.owner = owner_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= VACANT_CODE;
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                cnt_reg[i]     <= '0;
                prio_reg[i]    <= '0;
                timeout_reg[i] <= TIMEOUT_RESET;
            end
        end
        else
        begin
            if (accept)
            begin
                owner_reg <= owner_next;
                for (int i = 0; i < NUM_SOURCES; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
            if (cfg_we)
            begin
                for (int i = 0; i < NUM_SOURCES; i++)
                begin
                    if (cfg_addr == CFG_ADDR_W'(REG_PRIORITY0 + i))
                    begin
                        prio_reg[i] <= cfg_wdata[PRIO_W-1:0];
                    end
                    if (cfg_addr == CFG_ADDR_W'(REG_TIMEOUT0 + i))
                    begin
                        timeout_reg[i] <= cfg_wdata;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pmt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pmt_sva
    import pmt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                  m_axis_tuser
);

    logic [OWNER_W-1:0] owner_out;

    assign owner_out = m_axis_tdata[PAYLOAD_W+1 +: OWNER_W];

    // a dropped command or a tick never leaks payload bits
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[PAYLOAD_W-1:0] == '0))
        else $error("payload_out nonzero without forward");

    // a forwarded command makes its source the owner, so the owner shown is never vacant
    a_fwd_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (owner_out != VACANT_CODE))
        else $error("forward while output vacant");

    a_owner_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (owner_out <= VACANT_CODE))
        else $error("owner code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind priority_mux_with_timeouts_top pmt_sva u_pmt_sva (.*);

`default_nettype wire
